>>> hdl/wlo_pkg.sv
// shared widths, codes and types of the weight layout offset generator
package wlo_pkg;

    // request and response field widths
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned IDX_W      = 11;
    localparam int unsigned ROW_W      = 5;
    localparam int unsigned OFF_W      = 33;

    // configuration register widths
    localparam int unsigned CNT_W      = 12;
    localparam int unsigned DIM_W      = 6;
    localparam int unsigned BPE_W      = 2;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    // width of every value that goes through the constant dividers
    localparam int unsigned DIV_W      = 14;
    // width of a reciprocal multiplier
    localparam int unsigned MUL_W      = DIV_W + 1;

    // layout selector
    typedef enum logic [CMD_W-1:0] {
        CMD_PLAIN  = 2'd0,
        CMD_DIRECT = 2'd1,
        CMD_BIAS   = 2'd2,
        CMD_BAD    = 2'd3
    } t_cmd;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNEL_COUNT  = 3'd0,
        CFG_KERNEL_HEIGHT  = 3'd1,
        CFG_KERNEL_WIDTH   = 3'd2,
        CFG_KERNEL_COUNT   = 3'd3,
        CFG_BYTES_PER_ELEM = 3'd4
    } t_cfg_idx;

endpackage

>>> hdl/wlo_if.sv
// request, response and configuration channels of the weight layout offset generator

interface wlo_req_if;
    import wlo_pkg::*;

    logic             valid;
    logic             ready;
    t_cmd             command;
    logic [IDX_W-1:0] kernel_index;
    logic [IDX_W-1:0] channel_index;
    logic [ROW_W-1:0] row_index;
    logic [ROW_W-1:0] col_index;

    modport source (
        output valid, command, kernel_index, channel_index, row_index, col_index,
        input  ready
    );
    modport sink (
        input  valid, command, kernel_index, channel_index, row_index, col_index,
        output ready
    );
endinterface

interface wlo_rsp_if;
    import wlo_pkg::*;

    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] offset;
    logic             bad_format;

    modport source (output valid, offset, bad_format, input ready);
    modport sink (input valid, offset, bad_format, output ready);
endinterface

interface wlo_cfg_if;
    import wlo_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/weight_layout_offset.sv
// top level of the weight layout offset generator
//
// Turns a request (layout, kernel k, channel c, row h, column w) into the offset
// of that weight: the plain K-C-H-W element index, the packed direct-convolution
// byte offset (channel bytes in chunks of ATOMIC_BYTES, kernels in groups of
// GROUP_KERNELS, last partial chunk and group shrunk), or the bias layout
// c*W*H*bpe + h*W + w. An unknown layout gives bad_format with offset zero.
// The block takes one request per cycle while the response side does not stall;
// its depth comes from the eight register stages, each at most one multiply
// deep, that split the chunk and group divisions (reciprocal multiply,
// then correction) and the product chain of the packed layout. Every stage holds
// its own valid bit, so a stalled response only stops the stages behind it once
// they are full. Configuration writes are always taken and must only happen
// while no request is in flight.
module weight_layout_offset #(
    parameter int unsigned ATOMIC_BYTES  = 32,
    parameter int unsigned GROUP_KERNELS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    wlo_cfg_if.sink       i_cfg,
    wlo_req_if.sink       i_req,
    wlo_rsp_if.source     o_rsp
);
    import wlo_pkg::*;

    // stage count and derived widths
    localparam int unsigned NUM_ST  = 8;
    localparam int unsigned AW      = $clog2(ATOMIC_BYTES + 1);
    localparam int unsigned GW      = $clog2(GROUP_KERNELS + 1);
    localparam int unsigned HW_W    = 2 * DIM_W;
    localparam int unsigned HWID_W  = ROW_W + DIM_W;
    localparam int unsigned KCC_W   = IDX_W + CNT_W + 1;
    localparam int unsigned L0P_W   = KCC_W + HW_W;
    localparam int unsigned CHW_W   = IDX_W + HW_W;
    localparam int unsigned L2P_W   = CHW_W + BPE_W;
    localparam int unsigned HWCB_W  = HW_W + DIV_W;
    localparam int unsigned GB_W    = HWCB_W + GW;
    localparam int unsigned T1_W    = DIV_W + OFF_W;
    localparam int unsigned GKCS_W  = GW + AW;
    localparam int unsigned HWGK_W  = HW_W + GW;
    localparam int unsigned T3_W    = HWID_W + GKCS_W;
    localparam int unsigned T4_W    = ROW_W + GKCS_W;
    localparam int unsigned P2_W    = HWGK_W + AW;
    localparam int unsigned T2_W    = DIV_W + P2_W;

    // reciprocal constants for the two divisors
    localparam int unsigned A_SH = DIV_W + $clog2(ATOMIC_BYTES);
    localparam int unsigned G_SH = DIV_W + $clog2(GROUP_KERNELS);
    localparam logic [MUL_W-1:0] A_MUL = MUL_W'((2 ** A_SH) / ATOMIC_BYTES);
    localparam logic [MUL_W-1:0] G_MUL = MUL_W'((2 ** G_SH) / GROUP_KERNELS);
    localparam logic [DIV_W-1:0] A_D   = DIV_W'(ATOMIC_BYTES);
    localparam logic [DIV_W-1:0] G_D   = DIV_W'(GROUP_KERNELS);
    localparam logic [DIV_W-1:0] A_M1  = DIV_W'(ATOMIC_BYTES - 1);
    localparam logic [DIV_W-1:0] G_M1  = DIV_W'(GROUP_KERNELS - 1);
    localparam logic [AW-1:0]    A_SZ  = AW'(ATOMIC_BYTES);
    localparam logic [GW-1:0]    G_SZ  = GW'(GROUP_KERNELS);

    typedef struct packed {
        logic [DIV_W-1:0] q;
        logic [DIV_W-1:0] r;
    } t_div;

    // quotient estimate, equal to the true quotient or one below it
    function automatic logic [DIV_W-1:0] div_est(
        input logic [DIV_W-1:0] x,
        input logic [MUL_W-1:0] mul,
        input int unsigned      sh
    );
        logic [DIV_W+MUL_W-1:0] prod;
        prod = (DIV_W+MUL_W)'(x) * (DIV_W+MUL_W)'(mul);
        return DIV_W'(prod >> sh);
    endfunction

    // one compare and subtract finishes the division
    function automatic t_div div_fix(
        input logic [DIV_W-1:0] x,
        input logic [DIV_W-1:0] qe,
        input logic [DIV_W-1:0] d
    );
        logic [DIV_W-1:0] rem;
        t_div             res;
        rem = x - DIV_W'(qe * d);
        if (rem >= d) begin
            res.q = qe + 1'b1;
            res.r = rem - d;
        end else begin
            res.q = qe;
            res.r = rem;
        end
        return res;
    endfunction

    // configuration registers
    logic [CNT_W-1:0] r_cc;
    logic [DIM_W-1:0] r_kh;
    logic [DIM_W-1:0] r_kw;
    logic [CNT_W-1:0] r_kc;
    logic [BPE_W-1:0] r_bpe;

    // stage valid bits and advance enables
    logic [NUM_ST:1] r_vld;
    logic [NUM_ST:1] w_adv;
    logic [NUM_ST:1] w_vin;

    // stage 1
    t_cmd              r1_cmd;
    logic [IDX_W-1:0]  r1_k;
    logic [IDX_W-1:0]  r1_c;
    logic [ROW_W-1:0]  r1_w;
    logic [HW_W-1:0]   r1_hw;
    logic [DIV_W-1:0]  r1_cbytes;
    logic [DIV_W-1:0]  r1_cbt;
    logic [DIV_W-1:0]  r1_xc;
    logic [DIV_W-1:0]  r1_cb;
    logic [HWID_W-1:0] r1_hwid;
    logic [KCC_W-1:0]  r1_kcc;
    logic [DIV_W-1:0]  r1_kct;
    logic [DIV_W-1:0]  r1_kc;

    // stage 2
    t_cmd              r2_cmd;
    logic [ROW_W-1:0]  r2_w;
    logic [HW_W-1:0]   r2_hw;
    logic [HWID_W-1:0] r2_hwid;
    logic [DIV_W-1:0]  r2_x_cn, r2_qe_cn;
    logic [DIV_W-1:0]  r2_x_ct, r2_qe_ct;
    logic [DIV_W-1:0]  r2_x_cm, r2_qe_cm;
    logic [DIV_W-1:0]  r2_x_cb, r2_qe_cb;
    logic [DIV_W-1:0]  r2_x_k,  r2_qe_k;
    logic [DIV_W-1:0]  r2_x_gt, r2_qe_gt;
    logic [DIV_W-1:0]  r2_x_km, r2_qe_km;
    logic [OFF_W-1:0]  r2_l0;
    logic [CHW_W-1:0]  r2_chw;
    logic [HWCB_W-1:0] r2_hwcb;

    // stage 3
    t_cmd              r3_cmd;
    logic [ROW_W-1:0]  r3_w;
    logic [HW_W-1:0]   r3_hw;
    logic [HWID_W-1:0] r3_hwid;
    t_div              r3_cn;
    t_div              r3_ct;
    t_div              r3_cm;
    t_div              r3_cb;
    t_div              r3_k;
    t_div              r3_gt;
    t_div              r3_km;
    logic [OFF_W-1:0]  r3_l0;
    logic [OFF_W-1:0]  r3_l2;
    logic [OFF_W-1:0]  r3_gb;

    // stage 4
    t_cmd              r4_cmd;
    logic [ROW_W-1:0]  r4_w;
    logic [HW_W-1:0]   r4_hw;
    logic [HWID_W-1:0] r4_hwid;
    logic [AW-1:0]     r4_cs;
    logic [GW-1:0]     r4_gk;
    logic [GW-1:0]     r4_rk;
    logic [OFF_W-1:0]  r4_t1;
    logic              r4_cnz;
    logic [DIV_W-1:0]  r4_cnm1;
    logic [AW-1:0]     r4_t6;
    logic [OFF_W-1:0]  r4_l0;
    logic [OFF_W-1:0]  r4_l2;

    // stage 5
    t_cmd              r5_cmd;
    logic [ROW_W-1:0]  r5_w;
    logic [HWID_W-1:0] r5_hwid;
    logic [GKCS_W-1:0] r5_gkcs;
    logic [HWGK_W-1:0] r5_hwgk;
    logic [GKCS_W-1:0] r5_t5;
    logic [OFF_W-1:0]  r5_t1;
    logic              r5_cnz;
    logic [DIV_W-1:0]  r5_cnm1;
    logic [AW-1:0]     r5_t6;
    logic [OFF_W-1:0]  r5_l0;
    logic [OFF_W-1:0]  r5_l2;

    // stage 6
    t_cmd              r6_cmd;
    logic [T3_W-1:0]   r6_t3;
    logic [T4_W-1:0]   r6_t4;
    logic [P2_W-1:0]   r6_p2;
    logic [GKCS_W-1:0] r6_t5;
    logic [OFF_W-1:0]  r6_t1;
    logic              r6_cnz;
    logic [DIV_W-1:0]  r6_cnm1;
    logic [AW-1:0]     r6_t6;
    logic [OFF_W-1:0]  r6_l0;
    logic [OFF_W-1:0]  r6_l2;

    // stage 7
    t_cmd              r7_cmd;
    logic [OFF_W-1:0]  r7_t2;
    logic [OFF_W-1:0]  r7_s1;
    logic [OFF_W-1:0]  r7_s2;
    logic [OFF_W-1:0]  r7_l0;
    logic [OFF_W-1:0]  r7_l2;

    // stage 8, the response register
    logic [OFF_W-1:0]  r8_offset;
    logic              r8_bad;

    // configuration writes, always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc  <= CNT_W'(1);
            r_kh  <= DIM_W'(1);
            r_kw  <= DIM_W'(1);
            r_kc  <= CNT_W'(1);
            r_bpe <= BPE_W'(2);
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_CHANNEL_COUNT:  r_cc  <= i_cfg.data[CNT_W-1:0];
                CFG_KERNEL_HEIGHT:  r_kh  <= i_cfg.data[DIM_W-1:0];
                CFG_KERNEL_WIDTH:   r_kw  <= i_cfg.data[DIM_W-1:0];
                CFG_KERNEL_COUNT:   r_kc  <= i_cfg.data[CNT_W-1:0];
                CFG_BYTES_PER_ELEM: r_bpe <= i_cfg.data[BPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NUM_ST] = !r_vld[NUM_ST] || o_rsp.ready;
        for (int s = NUM_ST - 1; s >= 1; s--) begin
            w_adv[s] = !r_vld[s] || w_adv[s+1];
        end
    end

    assign w_vin       = {r_vld[NUM_ST-1:1], i_req.valid};
    assign i_req.ready = w_adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (w_adv & w_vin) | (~w_adv & r_vld);
        end
    end

    // stage 1: small products of the request and the sizes
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_cmd    <= i_req.command;
            r1_k      <= i_req.kernel_index;
            r1_c      <= i_req.channel_index;
            r1_w      <= i_req.col_index;
            r1_hw     <= HW_W'(r_kh) * HW_W'(r_kw);
            r1_cbytes <= DIV_W'(r_cc) * DIV_W'(r_bpe);
            r1_cbt    <= DIV_W'(r_cc) * DIV_W'(r_bpe) + A_M1;
            r1_xc     <= (DIV_W'(i_req.channel_index) + 1'b1) * DIV_W'(r_bpe) + A_M1;
            r1_cb     <= DIV_W'(i_req.channel_index) * DIV_W'(r_bpe);
            r1_hwid   <= HWID_W'(i_req.row_index) * HWID_W'(r_kw);
            r1_kcc    <= KCC_W'(i_req.kernel_index) * KCC_W'(r_cc)
                         + KCC_W'(i_req.channel_index);
            r1_kct    <= DIV_W'(r_kc) + G_M1;
            r1_kc     <= DIV_W'(r_kc);
        end
    end

    // stage 2: quotient estimates and the wide layout products
    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r2_cmd   <= r1_cmd;
            r2_w     <= r1_w;
            r2_hw    <= r1_hw;
            r2_hwid  <= r1_hwid;
            r2_x_cn  <= r1_xc;
            r2_qe_cn <= div_est(r1_xc, A_MUL, A_SH);
            r2_x_ct  <= r1_cbt;
            r2_qe_ct <= div_est(r1_cbt, A_MUL, A_SH);
            r2_x_cm  <= r1_cbytes;
            r2_qe_cm <= div_est(r1_cbytes, A_MUL, A_SH);
            r2_x_cb  <= r1_cb;
            r2_qe_cb <= div_est(r1_cb, A_MUL, A_SH);
            r2_x_k   <= DIV_W'(r1_k);
            r2_qe_k  <= div_est(DIV_W'(r1_k), G_MUL, G_SH);
            r2_x_gt  <= r1_kct;
            r2_qe_gt <= div_est(r1_kct, G_MUL, G_SH);
            r2_x_km  <= r1_kc;
            r2_qe_km <= div_est(r1_kc, G_MUL, G_SH);
            r2_l0    <= OFF_W'(L0P_W'(r1_kcc) * L0P_W'(r1_hw));
            r2_chw   <= CHW_W'(r1_c) * CHW_W'(r1_hw);
            r2_hwcb  <= HWCB_W'(r1_hw) * HWCB_W'(r1_cbytes);
        end
    end

    // stage 3: finish the divisions, close the plain and bias layouts
    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r3_cmd  <= r2_cmd;
            r3_w    <= r2_w;
            r3_hw   <= r2_hw;
            r3_hwid <= r2_hwid;
            r3_cn   <= div_fix(r2_x_cn, r2_qe_cn, A_D);
            r3_ct   <= div_fix(r2_x_ct, r2_qe_ct, A_D);
            r3_cm   <= div_fix(r2_x_cm, r2_qe_cm, A_D);
            r3_cb   <= div_fix(r2_x_cb, r2_qe_cb, A_D);
            r3_k    <= div_fix(r2_x_k, r2_qe_k, G_D);
            r3_gt   <= div_fix(r2_x_gt, r2_qe_gt, G_D);
            r3_km   <= div_fix(r2_x_km, r2_qe_km, G_D);
            r3_l0   <= r2_l0 + OFF_W'(r2_hwid) + OFF_W'(r2_w);
            r3_l2   <= OFF_W'(L2P_W'(r2_chw) * L2P_W'(r_bpe))
                       + OFF_W'(r2_hwid) + OFF_W'(r2_w);
            r3_gb   <= OFF_W'(GB_W'(r2_hwcb) * GB_W'(GROUP_KERNELS));
        end
    end

    // stage 4: chunk size and group size, group term
    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r4_cmd  <= r3_cmd;
            r4_w    <= r3_w;
            r4_hw   <= r3_hw;
            r4_hwid <= r3_hwid;
            // last chunk is shrunk to the leftover bytes
            if (r3_cn.q == r3_ct.q && r3_cm.r != '0) begin
                r4_cs <= AW'(r3_cm.r);
            end else begin
                r4_cs <= A_SZ;
            end
            // last group is shrunk to the leftover kernels
            if (r3_k.q + 1'b1 == r3_gt.q && r3_km.r != '0) begin
                r4_gk <= GW'(r3_km.r);
            end else begin
                r4_gk <= G_SZ;
            end
            r4_rk   <= GW'(r3_k.r);
            r4_t1   <= OFF_W'(T1_W'(r3_k.q) * T1_W'(r3_gb));
            r4_cnz  <= (r3_cn.q == '0);
            r4_cnm1 <= r3_cn.q - 1'b1;
            r4_t6   <= AW'(r3_cb.r);
            r4_l0   <= r3_l0;
            r4_l2   <= r3_l2;
        end
    end

    // stage 5: products of the chunk and group sizes
    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r5_cmd  <= r4_cmd;
            r5_w    <= r4_w;
            r5_hwid <= r4_hwid;
            r5_gkcs <= GKCS_W'(r4_gk) * GKCS_W'(r4_cs);
            r5_hwgk <= HWGK_W'(r4_hw) * HWGK_W'(r4_gk);
            r5_t5   <= GKCS_W'(r4_rk) * GKCS_W'(r4_cs);
            r5_t1   <= r4_t1;
            r5_cnz  <= r4_cnz;
            r5_cnm1 <= r4_cnm1;
            r5_t6   <= r4_t6;
            r5_l0   <= r4_l0;
            r5_l2   <= r4_l2;
        end
    end

    // stage 6: row and column terms, chunk stride
    always_ff @(posedge i_clk) begin
        if (w_adv[6]) begin
            r6_cmd  <= r5_cmd;
            r6_t3   <= T3_W'(r5_hwid) * T3_W'(r5_gkcs);
            r6_t4   <= T4_W'(r5_w) * T4_W'(r5_gkcs);
            r6_p2   <= P2_W'(r5_hwgk) * P2_W'(ATOMIC_BYTES);
            r6_t5   <= r5_t5;
            r6_t1   <= r5_t1;
            r6_cnz  <= r5_cnz;
            r6_cnm1 <= r5_cnm1;
            r6_t6   <= r5_t6;
            r6_l0   <= r5_l0;
            r6_l2   <= r5_l2;
        end
    end

    // stage 7: chunk term (wraps when the chunk number is zero), partial sums
    always_ff @(posedge i_clk) begin
        if (w_adv[7]) begin
            r7_cmd <= r6_cmd;
            if (r6_cnz) begin
                r7_t2 <= OFF_W'(0) - OFF_W'(r6_p2);
            end else begin
                r7_t2 <= OFF_W'(T2_W'(r6_cnm1) * T2_W'(r6_p2));
            end
            r7_s1  <= r6_t1 + OFF_W'(r6_t3);
            r7_s2  <= OFF_W'(r6_t4) + OFF_W'(r6_t5) + OFF_W'(r6_t6);
            r7_l0  <= r6_l0;
            r7_l2  <= r6_l2;
        end
    end

    // stage 8: layout select into the response register
    always_ff @(posedge i_clk) begin
        if (w_adv[8]) begin
            unique case (r7_cmd)
                CMD_PLAIN: begin
                    r8_offset <= r7_l0;
                    r8_bad    <= 1'b0;
                end
                CMD_DIRECT: begin
                    r8_offset <= r7_t2 + r7_s1 + r7_s2;
                    r8_bad    <= 1'b0;
                end
                CMD_BIAS: begin
                    r8_offset <= r7_l2;
                    r8_bad    <= 1'b0;
                end
                CMD_BAD: begin
                    r8_offset <= '0;
                    r8_bad    <= 1'b1;
                end
            endcase
        end
    end

    assign o_rsp.valid      = r_vld[NUM_ST];
    assign o_rsp.offset     = r8_offset;
    assign o_rsp.bad_format = r8_bad;

endmodule

>>> tb/tb_weight_layout_offset.sv
// testbench for the weight layout offset generator: directed and random requests checked in order
module tb_weight_layout_offset;
    timeunit 1ns;
    timeprecision 1ps;

    import wlo_pkg::*;

    localparam int unsigned ATOMIC        = 32;
    localparam int unsigned GROUP         = 16;
    localparam int unsigned QUIET_LIMIT   = 400;
    localparam int unsigned TAIL_CYCLES   = 16;
    localparam int unsigned PHASE_COUNT   = 10;
    localparam int unsigned PHASE_ITEMS   = 165;
    localparam int unsigned ODD_ITEMS     = 60;

    // expected result of one request
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic             bad_format;
    } t_offset_result;

    // one set of register values
    typedef struct {
        int unsigned chans;
        int unsigned rows;
        int unsigned cols;
        int unsigned kerns;
        int unsigned bpe;
    } t_sizes;

    // offset predictor with its own register copy and the queue of pending offsets
    class offset_scoreboard;
        bit [63:0]      chan_cnt;
        bit [63:0]      k_rows;
        bit [63:0]      k_cols;
        bit [63:0]      kern_cnt;
        bit [63:0]      elem_bytes;
        t_offset_result expected_offsets[$];
        int unsigned    mismatches;
        int unsigned    checked;

        function new();
            chan_cnt   = 1;
            k_rows     = 1;
            k_cols     = 1;
            kern_cnt   = 1;
            elem_bytes = 2;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int unsigned pending();
            return expected_offsets.size();
        endfunction

        // register write, masked to the register width
        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_CHANNEL_COUNT:  chan_cnt   = 64'(val[CNT_W-1:0]);
                CFG_KERNEL_HEIGHT:  k_rows     = 64'(val[DIM_W-1:0]);
                CFG_KERNEL_WIDTH:   k_cols     = 64'(val[DIM_W-1:0]);
                CFG_KERNEL_COUNT:   kern_cnt   = 64'(val[CNT_W-1:0]);
                CFG_BYTES_PER_ELEM: elem_bytes = 64'(val[BPE_W-1:0]);
                default: ;
            endcase
        endfunction

        // offset of one weight in the selected layout, wrapped to the output width
        function t_offset_result predict_offset(t_cmd cmd, bit [63:0] k, bit [63:0] c,
                                                bit [63:0] h, bit [63:0] w);
            t_offset_result r;
            bit [63:0]      atom;
            bit [63:0]      grp;
            bit [63:0]      area;
            bit [63:0]      chan_bytes;
            bit [63:0]      n_chunks;
            bit [63:0]      chunk_no;
            bit [63:0]      chunk_len;
            bit [63:0]      n_groups;
            bit [63:0]      group_no;
            bit [63:0]      group_len;
            bit [63:0]      group_stride;
            bit [63:0]      acc;
            r.bad_format = 1'b0;
            acc          = '0;
            atom         = 64'(ATOMIC);
            grp          = 64'(GROUP);
            area         = k_rows * k_cols;
            case (cmd)
                CMD_PLAIN: begin
                    acc = k * chan_cnt * area + c * area + h * k_cols + w;
                end
                CMD_DIRECT: begin
                    // channel bytes in atomic chunks, last one shrunk
                    chan_bytes = chan_cnt * elem_bytes;
                    n_chunks   = (chan_bytes + atom - 1) / atom;
                    chunk_no   = ((c + 1) * elem_bytes + atom - 1) / atom;
                    chunk_len  = atom;
                    if (chunk_no == n_chunks) begin
                        chunk_len = chan_bytes % atom;
                        if (chunk_len == 0) chunk_len = atom;
                    end
                    // kernels in groups, last one shrunk
                    n_groups     = (kern_cnt + grp - 1) / grp;
                    group_no     = (k + 1 + grp - 1) / grp;
                    group_stride = area * chan_bytes * grp;
                    group_len    = grp;
                    if (group_no == n_groups) begin
                        group_len = kern_cnt % grp;
                        if (group_len == 0) group_len = grp;
                    end
                    acc = (group_no - 1) * group_stride
                        + (chunk_no - 1) * area * group_len * atom
                        + h * k_cols * group_len * chunk_len
                        + w * group_len * chunk_len
                        + (k - grp * (group_no - 1)) * chunk_len
                        + (c * elem_bytes) % atom;
                end
                CMD_BIAS: begin
                    acc = c * k_cols * k_rows * elem_bytes + h * k_cols + w;
                end
                default: begin
                    r.bad_format = 1'b1;
                end
            endcase
            r.offset = acc[OFF_W-1:0];
            return r;
        endfunction

        function void note_request(t_cmd cmd, logic [IDX_W-1:0] k, logic [IDX_W-1:0] c,
                                   logic [ROW_W-1:0] h, logic [ROW_W-1:0] w);
            t_offset_result want;
            want = predict_offset(cmd, 64'(k), 64'(c), 64'(h), 64'(w));
            expected_offsets.insert(expected_offsets.size(), want);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t ns  mismatch: %s", $time, what);
        endtask

        // compare a response with the oldest pending offset
        task check_response(logic [OFF_W-1:0] got_off, logic got_bad);
            t_offset_result want;
            if (expected_offsets.size() == 0) begin
                report_mismatch($sformatf("unexpected response offset %0d bad_format %b",
                                          got_off, got_bad));
                return;
            end
            want = expected_offsets.pop_front();
            checked++;
            if (got_off !== want.offset)
                report_mismatch($sformatf("response %0d offset %0d, expected %0d",
                                          checked, got_off, want.offset));
            if (got_bad !== want.bad_format)
                report_mismatch($sformatf("response %0d bad_format %b, expected %b",
                                          checked, got_bad, want.bad_format));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    wlo_cfg_if cfg_ch ();
    wlo_req_if req_ch ();
    wlo_rsp_if rsp_ch ();

    offset_scoreboard sb;
    int unsigned      req_gap_max;
    int unsigned      rsp_stall_max;
    int unsigned      requests_sent;
    int unsigned      settings_loaded;
    int unsigned      quiet_cycles;

    weight_layout_offset #(
        .ATOMIC_BYTES  (ATOMIC),
        .GROUP_KERNELS (GROUP)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // clock
    always #1 i_clk = ~i_clk;

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (cfg_ch.valid && cfg_ch.ready)
                sb.write_reg(t_cfg_idx'(cfg_ch.index), cfg_ch.data);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.offset, rsp_ch.bad_format);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.command, req_ch.kernel_index, req_ch.channel_index,
                                req_ch.row_index, req_ch.col_index);
        end
        if ((cfg_ch.valid && cfg_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
                || (req_ch.valid && req_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("tb_weight_layout_offset: FAIL");
            $finish;
        end
    end

    // response side: random stall before each response
    initial begin
        int unsigned stall;
        rsp_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = $urandom_range(0, rsp_stall_max);
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            @(posedge i_clk);
            while (!rsp_ch.valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // one request, entered and left at a falling edge
    task automatic send_request(t_cmd cmd, logic [IDX_W-1:0] k, logic [IDX_W-1:0] c,
                                logic [ROW_W-1:0] h, logic [ROW_W-1:0] w);
        int unsigned gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid         = 1'b1;
        req_ch.command       = cmd;
        req_ch.kernel_index  = k;
        req_ch.channel_index = c;
        req_ch.row_index     = h;
        req_ch.col_index     = w;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        requests_sent++;
    endtask

    // hold requests until every pending offset has come back
    task automatic drain_pending();
        req_ch.valid = 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic put_reg(t_cfg_idx idx, int unsigned val);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // write all five registers while nothing is in flight
    task automatic load_sizes(t_sizes s);
        drain_pending();
        put_reg(CFG_CHANNEL_COUNT, s.chans);
        put_reg(CFG_KERNEL_HEIGHT, s.rows);
        put_reg(CFG_KERNEL_WIDTH, s.cols);
        put_reg(CFG_KERNEL_COUNT, s.kerns);
        put_reg(CFG_BYTES_PER_ELEM, s.bpe);
        cfg_ch.valid = 1'b0;
        settings_loaded++;
    endtask

    // index inside the configured size, leaning on both ends
    function automatic int unsigned pick_index(int unsigned size, int unsigned top);
        int unsigned last;
        if (size == 0) return $urandom_range(0, top);
        last = (size - 1 > top) ? top : size - 1;
        case ($urandom_range(0, 7))
            0:       return 0;
            1, 2:    return last;
            default: return $urandom_range(0, last);
        endcase
    endfunction

    // random request: mostly in range, some raw field noise
    task automatic send_random(t_sizes s);
        t_cmd             cmd;
        logic [IDX_W-1:0] k;
        logic [IDX_W-1:0] c;
        logic [ROW_W-1:0] h;
        logic [ROW_W-1:0] w;
        int unsigned      roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)       cmd = CMD_BAD;
        else if (roll < 50) cmd = CMD_DIRECT;
        else if (roll < 75) cmd = CMD_PLAIN;
        else                cmd = CMD_BIAS;
        if ($urandom_range(0, 7) == 0) begin
            k = IDX_W'($urandom_range(0, 2047));
            c = IDX_W'($urandom_range(0, 2047));
            h = ROW_W'($urandom_range(0, 31));
            w = ROW_W'($urandom_range(0, 31));
        end else begin
            k = IDX_W'(pick_index(s.kerns, 2047));
            c = IDX_W'(pick_index(s.chans, 2047));
            h = ROW_W'(pick_index(s.rows, 31));
            w = ROW_W'(pick_index(s.cols, 31));
        end
        send_request(cmd, k, c, h, w);
    endtask

    // stimulus
    initial begin
        t_sizes      plan[PHASE_COUNT];
        t_sizes      mid;
        int unsigned items;
        sb              = new();
        i_rst_n         = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.command  = CMD_PLAIN;
        req_ch.kernel_index  = '0;
        req_ch.channel_index = '0;
        req_ch.row_index     = '0;
        req_ch.col_index     = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_CHANNEL_COUNT;
        cfg_ch.data     = '0;
        req_gap_max     = 3;
        rsp_stall_max   = 3;
        requests_sent   = 0;
        settings_loaded = 0;
        quiet_cycles    = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values, every layout
        send_request(CMD_PLAIN, 0, 0, 0, 0);
        send_request(CMD_DIRECT, 0, 0, 0, 0);
        send_request(CMD_BIAS, 0, 0, 0, 0);
        send_request(CMD_BAD, 0, 0, 0, 0);

        // partial last chunk (80 channel bytes) and partial last group (20 kernels)
        mid = '{40, 3, 5, 20, 2};
        load_sizes(mid);
        send_request(CMD_PLAIN, 0, 0, 0, 0);
        send_request(CMD_PLAIN, 19, 39, 2, 4);
        send_request(CMD_PLAIN, 2047, 2047, 31, 31);
        send_request(CMD_DIRECT, 0, 0, 0, 0);
        send_request(CMD_DIRECT, 15, 15, 1, 3);
        send_request(CMD_DIRECT, 16, 16, 0, 0);
        send_request(CMD_DIRECT, 5, 32, 2, 1);
        send_request(CMD_DIRECT, 19, 39, 2, 4);
        // chunk and group numbers past the last ones
        send_request(CMD_DIRECT, 2047, 2047, 31, 31);
        send_request(CMD_BIAS, 0, 0, 0, 0);
        send_request(CMD_BIAS, 19, 39, 2, 4);
        send_request(CMD_BIAS, 2047, 2047, 31, 31);
        send_request(CMD_BAD, 2047, 2047, 31, 31);
        send_request(CMD_BAD, 11'h555, 11'h2aa, 5'h15, 5'h0a);

        // register settings: range ends, random, and out-of-range values
        plan[0] = '{1, 1, 1, 1, 1};
        plan[1] = '{2048, 32, 32, 2048, 2};
        for (int i = 2; i < 6; i++) begin
            plan[i].chans = $urandom_range(0, 1) ? $urandom_range(1, 64)
                                                 : $urandom_range(1, 2048);
            plan[i].rows  = $urandom_range(1, 32);
            plan[i].cols  = $urandom_range(1, 32);
            plan[i].kerns = $urandom_range(0, 1) ? $urandom_range(1, 64)
                                                 : $urandom_range(1, 2048);
            plan[i].bpe   = $urandom_range(1, 2);
        end
        plan[6] = '{17, 1, 1, 33, 1};
        plan[7] = '{1, 32, 1, 2048, 2};
        plan[8] = '{4095, 63, 63, 4095, 3};
        plan[9] = '{0, 0, 0, 0, 0};

        for (int p = 0; p < PHASE_COUNT; p++) begin
            load_sizes(plan[p]);
            items = (p < 8) ? PHASE_ITEMS : ODD_ITEMS;
            for (int n = 0; n < items; n++) begin
                // new idling mode now and then, sometimes none at all
                if (n % 48 == 0) begin
                    req_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 3;
                    rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
                end
                // pause the sender until the pipe is empty
                if (n == 80) drain_pending();
                send_random(plan[p]);
            end
        end

        drain_pending();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d offsets never returned", sb.pending()));
        $display("%0d requests over all layouts and %0d register settings, %0d responses checked",
                 requests_sent, settings_loaded, sb.checked);
        $display("%0d mismatches found", sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("tb_weight_layout_offset: PASS");
        end else begin
            $display("tb_weight_layout_offset: FAIL");
        end
        $finish;
    end

endmodule
